>>> rtl/edf_pkg.sv
// Package: types and constants shared by the EDF ready table.
package edf_pkg;

	localparam int SLOTS  = 32;
	localparam int WAIT_W = $clog2(SLOTS + 1);

	typedef enum logic [1:0] {
		OP_RELEASE  = 2'd0,
		OP_RUN      = 2'd1,
		OP_COMPLETE = 2'd2,
		OP_EXPIRE   = 2'd3
	} op_t;

	typedef struct packed {
		op_t         operation;
		logic [5:0]  job_id;
		logic [23:0] amount;
		logic [31:0] due_time;
	} cmd_t;

	typedef struct packed {
		logic        matched;
		logic        overflow;
		logic        pick_valid;
		logic [5:0]  pick_id;
		logic [23:0] pick_remaining;
		logic [31:0] pick_deadline;
		logic [15:0] done_count;
		logic [15:0] miss_count;
	} result_t;

	typedef struct packed {
		logic        valid;
		logic [5:0]  id;
		logic [23:0] remaining;
		logic [31:0] deadline;
	} entry_t;

	typedef struct packed {
		logic apply;
		cmd_t cmd;
	} cell_ctrl_t;

endpackage

>>> rtl/edf_cell.sv
// One table cell: holds a job, bubbles toward the head, carries a tally and a pick candidate.
module edf_cell import edf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cell_ctrl_t ctrl,
	input  logic       prev_valid,
	input  entry_t     up_entry,
	input  logic       tally_prev,
	input  logic       tally_up,
	input  entry_t     cand_in,
	output entry_t     entry,
	output logic       match,
	output logic       tally,
	output entry_t     cand
);

	logic        valid_q;
	logic [5:0]  id_q;
	logic [23:0] remaining_q;
	logic [31:0] deadline_q;
	logic        tally_q;
	entry_t      cand_q;
	logic        better;

	assign entry = '{valid: valid_q, id: id_q, remaining: remaining_q, deadline: deadline_q};
	assign match = valid_q && (id_q == ctrl.cmd.job_id);
	assign tally = tally_q;
	assign cand  = cand_q;

	assign better = valid_q && (!cand_in.valid || (deadline_q < cand_in.deadline) ||
		((deadline_q == cand_in.deadline) && (remaining_q < cand_in.remaining)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			tally_q <= 1'b0;
			cand_q  <= '0;
		end else begin
			cand_q <= better ? entry : cand_in;
			if (ctrl.apply) begin
				unique case (ctrl.cmd.operation)
					OP_RELEASE: begin
						if (!valid_q && prev_valid)
							valid_q <= 1'b1;
					end
					OP_RUN: begin
						if (match && (ctrl.cmd.amount >= remaining_q))
							valid_q <= 1'b0;
					end
					OP_COMPLETE: begin
						if (match) begin
							valid_q <= 1'b0;
							tally_q <= 1'b1;
						end
					end
					OP_EXPIRE: begin
						if (match) begin
							valid_q <= 1'b0;
							tally_q <= (remaining_q != '0);
						end
					end
					default: ;
				endcase
			end else begin
				if (!valid_q)
					valid_q <= up_entry.valid;
				else if (!prev_valid)
					valid_q <= 1'b0;
				tally_q <= tally_q ? tally_prev : tally_up;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.apply) begin
			if (ctrl.cmd.operation == OP_RELEASE) begin
				if (!valid_q && prev_valid) begin
					id_q        <= ctrl.cmd.job_id;
					remaining_q <= ctrl.cmd.amount;
					deadline_q  <= ctrl.cmd.due_time;
				end
			end else if (ctrl.cmd.operation == OP_RUN) begin
				if (match && (ctrl.cmd.amount < remaining_q))
					remaining_q <= remaining_q - ctrl.cmd.amount;
			end
		end else if (!valid_q) begin
			id_q        <= up_entry.id;
			remaining_q <= up_entry.remaining;
			deadline_q  <= up_entry.deadline;
		end
	end

endmodule

>>> rtl/edf_ready_table.sv
// Top level: EDF ready table built from a chain of job cells and a sequencing FSM.
// Each command is applied first; the chain then compacts and shifts counter tallies toward the
// head until it settles, and the pick then ripples down the chain while the FSM counts down in S_WAIT.
// One command at a time: start is taken only while busy is low.
// result_valid pulses for one cycle; the receiver cannot stall it.
// Reset: table empty, both counters zero, no result pending.
module edf_ready_table import edf_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  cmd_t    cmd,
	output logic    busy,
	output logic    result_valid,
	output result_t result
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SETTLE,
		S_WAIT
	} state_t;

	state_t            state_q;
	logic [WAIT_W-1:0] wait_q;
	logic [15:0]       done_q;
	logic [15:0]       miss_q;
	logic              matched_q;
	logic              overflow_q;
	op_t               op_q;
	logic              result_valid_q;
	result_t           result_q;

	cell_ctrl_t        ctrl;
	entry_t            ent  [SLOTS];
	entry_t            cand [SLOTS];
	logic [SLOTS-1:0]  mat;
	logic [SLOTS-1:0]  tal;
	logic [SLOTS-1:0]  hole;
	logic              accept;
	logic              settled;
	entry_t            best;

	assign accept       = start && (state_q == S_IDLE);
	assign busy         = (state_q != S_IDLE);
	assign ctrl         = '{apply: accept, cmd: cmd};
	assign result_valid = result_valid_q;
	assign result       = result_q;
	assign best         = cand[SLOTS-1];

	for (genvar i = 0; i < SLOTS; i++) begin : g_cell
		logic   prev_v;
		logic   tprev;
		logic   tup;
		entry_t up;
		entry_t cin;

		if (i == 0) begin : g_head
			assign prev_v = 1'b1;
			assign tprev  = 1'b0;
			assign cin    = '0;
		end else begin : g_body
			assign prev_v = ent[i-1].valid;
			assign tprev  = tal[i-1];
			assign cin    = cand[i-1];
		end
		if (i == SLOTS - 1) begin : g_tail
			assign up  = '0;
			assign tup = 1'b0;
			assign hole[i] = 1'b0;
		end else begin : g_inner
			assign up  = ent[i+1];
			assign tup = tal[i+1];
			assign hole[i] = !ent[i].valid && ent[i+1].valid;
		end

		edf_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.prev_valid (prev_v),
			.up_entry   (up),
			.tally_prev (tprev),
			.tally_up   (tup),
			.cand_in    (cin),
			.entry      (ent[i]),
			.match      (mat[i]),
			.tally      (tal[i]),
			.cand       (cand[i])
		);
	end

	assign settled = (hole == '0) && (tal == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			wait_q         <= '0;
			done_q         <= '0;
			miss_q         <= '0;
			matched_q      <= 1'b0;
			overflow_q     <= 1'b0;
			op_q           <= OP_RELEASE;
			result_valid_q <= 1'b0;
			result_q       <= '0;
		end else begin
			result_valid_q <= 1'b0;
			if (tal[0]) begin
				if (op_q == OP_COMPLETE) begin
					if (done_q != 16'hFFFF)
						done_q <= done_q + 16'd1;
				end else if (miss_q != 16'hFFFF) begin
					miss_q <= miss_q + 16'd1;
				end
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q       <= cmd.operation;
						matched_q  <= (cmd.operation != OP_RELEASE) && (mat != '0);
						overflow_q <= (cmd.operation == OP_RELEASE) && ent[SLOTS-1].valid;
						state_q    <= S_SETTLE;
					end
				end
				S_SETTLE: begin
					if (settled) begin
						wait_q  <= WAIT_W'(SLOTS);
						state_q <= S_WAIT;
					end
				end
				S_WAIT: begin
					if (wait_q == '0) begin
						result_valid_q          <= 1'b1;
						result_q.matched        <= matched_q;
						result_q.overflow       <= overflow_q;
						result_q.pick_valid     <= best.valid;
						result_q.pick_id        <= best.valid ? best.id : '0;
						result_q.pick_remaining <= best.valid ? best.remaining : '0;
						result_q.pick_deadline  <= best.valid ? best.deadline : '0;
						result_q.done_count     <= done_q;
						result_q.miss_count     <= miss_q;
						state_q                 <= S_IDLE;
					end else begin
						wait_q <= wait_q - WAIT_W'(1);
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

>>> dv/tb_edf_ready_table.sv
// Testbench for edf_ready_table: random and directed job commands checked against a table predictor.
`timescale 1ns / 100ps

module tb_edf_ready_table;
	import edf_pkg::*;

	localparam int          RAND_ITEMS = 1080;
	localparam int unsigned LIMIT      = 1_200_000;
	localparam int          TAIL       = 3 * SLOTS + 16;

	typedef struct {
		cmd_t c;
		bit   hold;
	} job_cmd_t;

	logic    clk    = 1'b0;
	logic    arst_n = 1'b0;
	logic    start  = 1'b0;
	cmd_t    cmd    = '0;
	logic    busy;
	logic    result_valid;
	result_t result;

	edf_ready_table i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.cmd          (cmd),
		.busy         (busy),
		.result_valid (result_valid),
		.result       (result)
	);

	// predicted table contents, compacted in arrival order
	logic [5:0]  tab_id   [SLOTS];
	logic [23:0] tab_left [SLOTS];
	logic [31:0] tab_due  [SLOTS];
	int          held       = 0;
	int          held_peak  = 0;
	logic [15:0] done_tally = '0;
	logic [15:0] miss_tally = '0;

	job_cmd_t    sched_cmds[$];
	result_t     picks_due[$];
	logic [5:0]  ids_seen[$];
	result_t     want;
	result_t     pred;
	logic        taken     = 1'b0;
	int          gap_left  = 0;
	int          issued    = 0;
	int unsigned cycles    = 0;
	int          errors    = 0;
	int          n_checked = 0;
	int          n_hits    = 0;
	int          n_ovf     = 0;

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic result_t edf_apply(input cmd_t c);
		result_t r;
		int      kept;
		int      best;
		bit      keep;
		r = '0;
		if (c.operation == OP_RELEASE) begin
			if (held < SLOTS) begin
				tab_id[held]   = c.job_id;
				tab_left[held] = c.amount;
				tab_due[held]  = c.due_time;
				held++;
			end else begin
				r.overflow = 1'b1;
			end
		end else begin
			kept = 0;
			for (int i = 0; i < held; i++) begin
				keep = 1'b1;
				if (tab_id[i] == c.job_id) begin
					r.matched = 1'b1;
					case (c.operation)
						OP_RUN: begin
							if (c.amount < tab_left[i])
								tab_left[i] = tab_left[i] - c.amount;
							else
								keep = 1'b0;
						end
						OP_COMPLETE: begin
							if (done_tally != 16'hFFFF)
								done_tally++;
							keep = 1'b0;
						end
						default: begin
							if (tab_left[i] != '0 && miss_tally != 16'hFFFF)
								miss_tally++;
							keep = 1'b0;
						end
					endcase
				end
				if (keep) begin
					tab_id[kept]   = tab_id[i];
					tab_left[kept] = tab_left[i];
					tab_due[kept]  = tab_due[i];
					kept++;
				end
			end
			held = kept;
		end
		if (held > held_peak)
			held_peak = held;
		best = -1;
		for (int i = 0; i < held; i++) begin
			if (best < 0 || tab_due[i] < tab_due[best] ||
					(tab_due[i] == tab_due[best] && tab_left[i] < tab_left[best]))
				best = i;
		end
		if (best >= 0) begin
			r.pick_valid     = 1'b1;
			r.pick_id        = tab_id[best];
			r.pick_remaining = tab_left[best];
			r.pick_deadline  = tab_due[best];
		end
		r.done_count = done_tally;
		r.miss_count = miss_tally;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [31:0] exp_v, input logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t ns: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
			errors++;
		end
	endtask

	function automatic int pick_gap();
		int r;
		if (((issued / 150) % 3) == 2)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 4);
		return $urandom_range(10, 120);
	endfunction

	function automatic logic [23:0] rand_ticks();
		case ($urandom_range(0, 5))
			0:       return 24'd0;
			1:       return 24'hFFFFFF;
			2, 3:    return 24'($urandom_range(0, 20));
			default: return 24'($urandom);
		endcase
	endfunction

	function automatic logic [31:0] rand_due();
		case ($urandom_range(0, 5))
			0:       return 32'd0;
			1:       return 32'hFFFFFFFF;
			2, 3:    return 32'($urandom_range(0, 15));
			default: return 32'($urandom);
		endcase
	endfunction

	task automatic push_cmd(input op_t op, input logic [5:0] id, input logic [23:0] amt,
			input logic [31:0] due, input bit hold);
		job_cmd_t j;
		j.c.operation = op;
		j.c.job_id    = id;
		j.c.amount    = amt;
		j.c.due_time  = due;
		j.hold        = hold;
		sched_cmds.insert(sched_cmds.size(), j);
		if (op == OP_RELEASE) begin
			ids_seen.insert(ids_seen.size(), id);
			if (ids_seen.size() > 40)
				void'(ids_seen.pop_front());
		end
	endtask

	// driver
	always @(negedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else if (start && !taken) begin
			start <= 1'b1;
		end else if (gap_left > 0) begin
			gap_left--;
			start <= 1'b0;
		end else if (sched_cmds.size() > 0 && !(sched_cmds[0].hold && picks_due.size() > 0)) begin
			cmd      <= sched_cmds[0].c;
			start    <= 1'b1;
			void'(sched_cmds.pop_front());
			issued++;
			gap_left = pick_gap();
		end else begin
			start <= 1'b0;
		end
	end

	// monitor and predictor update
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("%0t ns: timeout, %0d results still expected", $time, picks_due.size());
			$display("status: fail");
			$finish;
		end else if (arst_n) begin
			if (result_valid) begin
				if (picks_due.size() == 0) begin
					$display("%0t ns: unexpected result %0h", $time, result);
					errors++;
				end else begin
					want = picks_due.pop_front();
					check_field("matched", 32'(want.matched), 32'(result.matched));
					check_field("overflow", 32'(want.overflow), 32'(result.overflow));
					check_field("pick_valid", 32'(want.pick_valid), 32'(result.pick_valid));
					check_field("pick_id", 32'(want.pick_id), 32'(result.pick_id));
					check_field("pick_remaining", 32'(want.pick_remaining),
						32'(result.pick_remaining));
					check_field("pick_deadline", want.pick_deadline, result.pick_deadline);
					check_field("done_count", 32'(want.done_count), 32'(result.done_count));
					check_field("miss_count", 32'(want.miss_count), 32'(result.miss_count));
					n_checked++;
				end
			end
			if (start && !busy) begin
				pred = edf_apply(cmd);
				if (pred.overflow)
					n_ovf++;
				if (pred.matched)
					n_hits++;
				picks_due.insert(picks_due.size(), pred);
			end
			taken <= start && !busy;
		end
	end

	initial begin
		int         rel_pct;
		op_t        op;
		logic [5:0] id;

		// lookups on an empty table
		push_cmd(OP_COMPLETE, 6'd12, 24'd0, 32'd0, 1'b0);
		push_cmd(OP_EXPIRE, 6'd12, 24'd0, 32'd0, 1'b0);
		push_cmd(OP_RUN, 6'd12, 24'd5, 32'd0, 1'b0);
		// zero work, extremes, ties, duplicate id
		push_cmd(OP_RELEASE, 6'd0, 24'd0, 32'd0, 1'b0);
		push_cmd(OP_RELEASE, 6'd63, 24'hFFFFFF, 32'hFFFFFFFF, 1'b0);
		push_cmd(OP_RELEASE, 6'd5, 24'd10, 32'd0, 1'b0);
		push_cmd(OP_RELEASE, 6'd7, 24'd10, 32'd0, 1'b0);
		push_cmd(OP_RELEASE, 6'd5, 24'd3, 32'd100, 1'b0);
		push_cmd(OP_RUN, 6'd5, 24'd4, 32'd0, 1'b0);
		push_cmd(OP_RUN, 6'd63, 24'hFFFFFF, 32'd0, 1'b0);
		push_cmd(OP_EXPIRE, 6'd0, 24'd0, 32'd0, 1'b0);
		push_cmd(OP_EXPIRE, 6'd7, 24'd0, 32'd0, 1'b0);
		push_cmd(OP_COMPLETE, 6'd5, 24'd0, 32'd0, 1'b0);
		push_cmd(OP_RUN, 6'd40, 24'd1, 32'd0, 1'b0);
		push_cmd(OP_RELEASE, 6'd33, 24'h800000, 32'h80000000, 1'b0);
		push_cmd(OP_RELEASE, 6'd21, 24'h7FFFFF, 32'h7FFFFFFF, 1'b0);
		push_cmd(OP_RELEASE, 6'd42, 24'd1, 32'h7FFFFFFF, 1'b0);
		push_cmd(OP_RUN, 6'd42, 24'd0, 32'd0, 1'b0);
		push_cmd(OP_RUN, 6'd42, 24'd1, 32'd0, 1'b0);
		push_cmd(OP_COMPLETE, 6'd33, 24'd0, 32'd0, 1'b0);
		push_cmd(OP_EXPIRE, 6'd21, 24'd0, 32'd0, 1'b0);

		// alternate fill-heavy and drain-heavy phases
		for (int n = 0; n < RAND_ITEMS; n++) begin
			rel_pct = ((n / 100) % 2 == 0) ? 75 : 30;
			if ($urandom_range(0, 99) < rel_pct)
				op = OP_RELEASE;
			else
				op = op_t'($urandom_range(1, 3));
			if (op == OP_RELEASE || ids_seen.size() == 0 || $urandom_range(0, 9) < 2)
				id = 6'($urandom_range(0, 63));
			else
				id = ids_seen[$urandom_range(0, ids_seen.size() - 1)];
			push_cmd(op, id, rand_ticks(), rand_due(), n % 360 == 0);
		end

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (sched_cmds.size() > 0 || start || picks_due.size() > 0)
			@(negedge clk);
		repeat (TAIL) @(negedge clk);

		$display("%0d commands checked, %0d matched lookups, %0d overflows, peak occupancy %0d",
			n_checked, n_hits, n_ovf, held_peak);
		$display("completions %0d, misses %0d, errors %0d", done_tally, miss_tally, errors);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

>>> filelist.f
rtl/edf_pkg.sv
rtl/edf_cell.sv
rtl/edf_ready_table.sv
dv/tb_edf_ready_table.sv
